// ===== rtl/dkct_pkg.sv =====
// ----------------------------------------------------------------------------
// dkct_pkg
// Shared constants and types for the date keyed count table.
// ----------------------------------------------------------------------------
package dkct_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);

  localparam int OPCODE_W  = 2;
  localparam int KEY_W     = 27;
  localparam int YEAR_W    = 14;
  localparam int MONTH_W   = 4;
  localparam int CNT_W     = 16;
  localparam int ENTRIES_W = 10;
  // month bounds built from 14-bit year and 4-bit month fit in 28 bits
  localparam int MKEY_W    = 28;

  localparam logic [OPCODE_W-1:0] OP_RECORD = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_MONTH  = 2'd2;

  localparam logic [MKEY_W-1:0] KEY_YEAR_MUL  = MKEY_W'(10000);
  localparam logic [MKEY_W-1:0] KEY_MONTH_MUL = MKEY_W'(100);
  localparam logic [MKEY_W-1:0] DAY_FIRST     = MKEY_W'(1);
  localparam logic [MKEY_W-1:0] DAY_LAST      = MKEY_W'(31);
  localparam logic [CNT_W-1:0]  CNT_MAX       = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_ONE       = CNT_W'(1);

  typedef struct packed {
    logic [KEY_W-1:0] date;
    logic [CNT_W-1:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/dkct_in_if.sv =====
// ----------------------------------------------------------------------------
// dkct_in_if
// Request channel: opcode, date key and year/month with valid/ready.
// ----------------------------------------------------------------------------
interface dkct_in_if;
  import dkct_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [KEY_W-1:0]    day_key;
  logic [YEAR_W-1:0]   year;
  logic [MONTH_W-1:0]  month;

  modport source (output valid, opcode, day_key, year, month, input ready);
  modport sink   (input valid, opcode, day_key, year, month, output ready);
endinterface

// ===== rtl/dkct_out_if.sv =====
// ----------------------------------------------------------------------------
// dkct_out_if
// Result channel: page count and table fill with valid/ready.
// ----------------------------------------------------------------------------
interface dkct_out_if;
  import dkct_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CNT_W-1:0]     pages;
  logic [ENTRIES_W-1:0] entries_used;

  modport source (output valid, pages, entries_used, input ready);
  modport sink   (input valid, pages, entries_used, output ready);
endinterface

// ===== rtl/dkct_ram.sv =====
// ----------------------------------------------------------------------------
// dkct_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dkct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/date_keyed_count_table.sv =====
// ----------------------------------------------------------------------------
// date_keyed_count_table
// Sorted date table with per-date counters, point and month-max queries.
// ----------------------------------------------------------------------------
// Flow: request captured in IDLE, month bounds set in PREP, table entries read
//   in order in SCAN, entries moved in SHIFT when an insert opens a gap, and
//   the result loaded into the output register in DONE.
// Throughput: one transfer at a time; next request taken the cycle after the
//   result is queued in the output register; DONE holds while the previous
//   result waits for out ready.
// Reset: fill level, sequencer and output valid cleared; RAM contents are
//   not cleared, only entries below the fill level are ever read.
// ----------------------------------------------------------------------------
module date_keyed_count_table (
  input logic    clk,
  input logic    rst_n,
  dkct_in_if.sink    in_s,
  dkct_out_if.source out_s
);
  import dkct_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_SCAN, S_SHIFT, S_DONE} state_t;

  state_t               state_r, state_nxt;
  logic [OPCODE_W-1:0]  op_r, op_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [YEAR_W-1:0]    year_r, year_nxt;
  logic [MONTH_W-1:0]   month_r, month_nxt;
  logic [MKEY_W-1:0]    lo_r, lo_nxt, hi_r, hi_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [FILL_W-1:0]    idx_r, idx_nxt;
  logic [FILL_W-1:0]    rem_r, rem_nxt;
  logic                 rv_r, rv_nxt;
  logic [ADDR_W-1:0]    ra_r, ra_nxt;
  logic [CNT_W-1:0]     best_r, best_nxt;
  logic                 dir_up_r, dir_up_nxt;
  logic [ADDR_W-1:0]    ins_addr_r, ins_addr_nxt;
  logic [CNT_W-1:0]     res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]     out_pages_r, out_pages_nxt;
  logic [ENTRIES_W-1:0] out_entries_r, out_entries_nxt;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  entry_t               ram_wdata, ram_rdata;

  dkct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_s.ready         = (state_r == S_IDLE);
  assign out_s.valid        = out_valid_r;
  assign out_s.pages        = out_pages_r;
  assign out_s.entries_used = out_entries_r;

  always_comb begin
    logic              issue;
    logic              do_ins;
    logic [FILL_W-1:0] ins_pos;
    logic [CNT_W-1:0]  cnt_inc;
    logic [MKEY_W-1:0] rd_key;

    state_nxt       = state_r;
    op_nxt          = op_r;
    key_nxt         = key_r;
    year_nxt        = year_r;
    month_nxt       = month_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    fill_nxt        = fill_r;
    idx_nxt         = idx_r;
    rem_nxt         = rem_r;
    rv_nxt          = 1'b0;
    ra_nxt          = idx_r[ADDR_W-1:0];
    best_nxt        = best_r;
    dir_up_nxt      = dir_up_r;
    ins_addr_nxt    = ins_addr_r;
    res_nxt         = res_r;
    out_valid_nxt   = out_valid_r & ~out_s.ready;
    out_pages_nxt   = out_pages_r;
    out_entries_nxt = out_entries_r;

    ram_we    = 1'b0;
    ram_waddr = ra_r;
    ram_wdata = ram_rdata;
    ram_raddr = idx_r[ADDR_W-1:0];

    issue   = 1'b0;
    do_ins  = 1'b0;
    ins_pos = fill_r;
    cnt_inc = (ram_rdata.count == CNT_MAX) ? CNT_MAX : ram_rdata.count + CNT_ONE;
    rd_key  = MKEY_W'(ram_rdata.date);

    case (state_r)
      S_IDLE: begin
        if (in_s.valid) begin
          op_nxt    = in_s.opcode;
          key_nxt   = in_s.day_key;
          year_nxt  = in_s.year;
          month_nxt = in_s.month;
          state_nxt = S_PREP;
        end
      end

      S_PREP: begin
        lo_nxt   = MKEY_W'(year_r) * KEY_YEAR_MUL + MKEY_W'(month_r) * KEY_MONTH_MUL
                   + DAY_FIRST;
        hi_nxt   = MKEY_W'(year_r) * KEY_YEAR_MUL + MKEY_W'(month_r) * KEY_MONTH_MUL
                   + DAY_LAST;
        idx_nxt  = '0;
        best_nxt = '0;
        res_nxt  = '0;
        if ((op_r == OP_RECORD && key_r == '0) ||
            !(op_r == OP_RECORD || op_r == OP_QUERY || op_r == OP_MONTH)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // stream reads; registered RAM data for ra_r arrives together with rv_r
        issue = (idx_r < fill_r);
        if (issue) begin
          idx_nxt = idx_r + FILL_W'(1);
        end
        rv_nxt = issue;
        if (rv_r) begin
          case (op_r)
            OP_RECORD: begin
              if (ram_rdata.date >= key_r) begin
                if (ram_rdata.date == key_r) begin
                  ram_we          = 1'b1;
                  ram_waddr       = ra_r;
                  ram_wdata.date  = key_r;
                  ram_wdata.count = cnt_inc;
                  res_nxt         = cnt_inc;
                  rv_nxt          = 1'b0;
                  state_nxt       = S_DONE;
                end else begin
                  do_ins  = 1'b1;
                  ins_pos = FILL_W'(ra_r);
                end
              end
            end
            OP_QUERY: begin
              if (ram_rdata.date >= key_r) begin
                res_nxt   = (ram_rdata.date == key_r) ? ram_rdata.count : '0;
                rv_nxt    = 1'b0;
                state_nxt = S_DONE;
              end
            end
            default: begin
              if (rd_key >= lo_r && rd_key <= hi_r && ram_rdata.count > best_r) begin
                best_nxt = ram_rdata.count;
              end
            end
          endcase
        end else if (!issue) begin
          // walked past the last entry without a stop
          case (op_r)
            OP_RECORD: begin
              do_ins  = 1'b1;
              ins_pos = fill_r;
            end
            OP_QUERY: begin
              res_nxt   = '0;
              state_nxt = S_DONE;
            end
            default: begin
              res_nxt   = best_r;
              state_nxt = S_DONE;
            end
          endcase
        end

        if (do_ins) begin
          rv_nxt          = 1'b0;
          ram_wdata.date  = key_r;
          ram_wdata.count = CNT_ONE;
          if (fill_r < FILL_W'(TABLE_DEPTH)) begin
            if (ins_pos == fill_r) begin
              ram_we    = 1'b1;
              ram_waddr = ins_pos[ADDR_W-1:0];
              fill_nxt  = fill_r + FILL_W'(1);
              res_nxt   = CNT_ONE;
              state_nxt = S_DONE;
            end else begin
              // open a gap at ins_pos: move entries up, top first
              dir_up_nxt   = 1'b1;
              idx_nxt      = fill_r - FILL_W'(1);
              rem_nxt      = fill_r - ins_pos;
              ins_addr_nxt = ins_pos[ADDR_W-1:0];
              state_nxt    = S_SHIFT;
            end
          end else begin
            if (ins_pos == '0) begin
              // new date is the smallest and drops out at once
              res_nxt   = '0;
              state_nxt = S_DONE;
            end else if (ins_pos == FILL_W'(1)) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              res_nxt   = CNT_ONE;
              state_nxt = S_DONE;
            end else begin
              // full: drop entry 0, move entries down, bottom first
              dir_up_nxt   = 1'b0;
              idx_nxt      = FILL_W'(1);
              rem_nxt      = ins_pos - FILL_W'(1);
              ins_addr_nxt = ADDR_W'(ins_pos - FILL_W'(1));
              state_nxt    = S_SHIFT;
            end
          end
        end
      end

      S_SHIFT: begin
        issue = (rem_r != '0);
        if (issue) begin
          rem_nxt = rem_r - FILL_W'(1);
          idx_nxt = dir_up_r ? idx_r - FILL_W'(1) : idx_r + FILL_W'(1);
        end
        rv_nxt = issue;
        if (rv_r) begin
          ram_we    = 1'b1;
          ram_waddr = dir_up_r ? ra_r + ADDR_W'(1) : ra_r - ADDR_W'(1);
          ram_wdata = ram_rdata;
        end else if (!issue) begin
          ram_we          = 1'b1;
          ram_waddr       = ins_addr_r;
          ram_wdata.date  = key_r;
          ram_wdata.count = CNT_ONE;
          res_nxt         = CNT_ONE;
          if (dir_up_r) begin
            fill_nxt = fill_r + FILL_W'(1);
          end
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_s.ready) begin
          out_valid_nxt   = 1'b1;
          out_pages_nxt   = res_r;
          out_entries_nxt = ENTRIES_W'(fill_r);
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r          <= op_nxt;
    key_r         <= key_nxt;
    year_r        <= year_nxt;
    month_r       <= month_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    idx_r         <= idx_nxt;
    rem_r         <= rem_nxt;
    ra_r          <= ra_nxt;
    best_r        <= best_nxt;
    dir_up_r      <= dir_up_nxt;
    ins_addr_r    <= ins_addr_nxt;
    res_r         <= res_nxt;
    out_pages_r   <= out_pages_nxt;
    out_entries_r <= out_entries_nxt;
  end

endmodule

// ===== tb/sv/tb_date_keyed_count_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_date_keyed_count_table
// Self-checking bench for the sorted date count table: a scoreboard keeps
// its own sorted table and predicts every reply; records, date queries and
// month queries are driven in a fixed-length random run meant to fill the table
// and make it evict, with random sender gaps and stretches of receiver stalls.
// ----------------------------------------------------------------------------
module tb_date_keyed_count_table;
  import dkct_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 620;
  localparam int unsigned IDLE_LIMIT   = 20000;
  localparam int unsigned DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;
  localparam logic [KEY_W-1:0] KEY_LAST = KEY_W'(99991231);

  typedef struct {
    logic [OPCODE_W-1:0] opcode;
    logic [KEY_W-1:0]    day_key;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
  } request_t;

  typedef struct {
    logic [CNT_W-1:0]     pages;
    logic [ENTRIES_W-1:0] entries;
  } tally_t;

  class page_tally_scoreboard;
    logic [KEY_W-1:0] dates  [TABLE_DEPTH];
    logic [CNT_W-1:0] counts [TABLE_DEPTH];
    int unsigned fill;
    int unsigned peak_fill;
    int unsigned mismatches;
    int unsigned replies_checked;
    tally_t expected_tallies[$];

    function new();
      fill = 0;
      peak_fill = 0;
      mismatches = 0;
      replies_checked = 0;
    endfunction

    function bit holds(logic [KEY_W-1:0] key);
      for (int i = 0; i < fill; i++)
        if (dates[i] == key) return 1'b1;
      return 1'b0;
    endfunction

    function logic [CNT_W-1:0] record_page(logic [KEY_W-1:0] key);
      int unsigned pos;
      if (key == '0) return '0;
      for (int i = 0; i < fill; i++) begin
        if (dates[i] == key) begin
          if (counts[i] != CNT_MAX) counts[i] = counts[i] + CNT_ONE;
          return counts[i];
        end
      end
      pos = 0;
      while (pos < fill && dates[pos] < key) pos++;
      if (fill >= TABLE_DEPTH) begin
        // full: the smallest date drops out, which may be the new one
        if (pos == 0) return '0;
        for (int i = 0; i + 1 < pos; i++) begin
          dates[i]  = dates[i + 1];
          counts[i] = counts[i + 1];
        end
        dates[pos - 1]  = key;
        counts[pos - 1] = CNT_ONE;
        return CNT_ONE;
      end
      for (int i = fill; i > pos; i--) begin
        dates[i]  = dates[i - 1];
        counts[i] = counts[i - 1];
      end
      dates[pos]  = key;
      counts[pos] = CNT_ONE;
      fill++;
      if (fill > peak_fill) peak_fill = fill;
      return CNT_ONE;
    endfunction

    function logic [CNT_W-1:0] date_count(logic [KEY_W-1:0] key);
      for (int i = 0; i < fill; i++)
        if (dates[i] == key) return counts[i];
      return '0;
    endfunction

    function logic [CNT_W-1:0] month_peak(logic [YEAR_W-1:0] year, logic [MONTH_W-1:0] month);
      logic [31:0] lo;
      logic [31:0] hi;
      logic [CNT_W-1:0] best;
      lo = 32'(year) * 32'(KEY_YEAR_MUL) + 32'(month) * 32'(KEY_MONTH_MUL) + 32'(DAY_FIRST);
      hi = 32'(year) * 32'(KEY_YEAR_MUL) + 32'(month) * 32'(KEY_MONTH_MUL) + 32'(DAY_LAST);
      best = '0;
      for (int i = 0; i < fill; i++)
        if (32'(dates[i]) >= lo && 32'(dates[i]) <= hi && counts[i] > best)
          best = counts[i];
      return best;
    endfunction

    function void accept_request(request_t req);
      tally_t t;
      case (req.opcode)
        OP_RECORD: t.pages = record_page(req.day_key);
        OP_QUERY:  t.pages = date_count(req.day_key);
        OP_MONTH:  t.pages = month_peak(req.year, req.month);
        default:   t.pages = '0;
      endcase
      t.entries = ENTRIES_W'(fill);
      expected_tallies.push_back(t);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("[%0t] mismatch on %s: got %0d, expected %0d (reply %0d)",
               $realtime, what, got, want, replies_checked);
    endtask

    task check_reply(logic [CNT_W-1:0] pages, logic [ENTRIES_W-1:0] entries);
      tally_t want;
      replies_checked++;
      if (expected_tallies.size() == 0) begin
        report_mismatch("unrequested reply pages", 32'(pages), 32'd0);
        return;
      end
      want = expected_tallies.pop_front();
      if (pages !== want.pages) report_mismatch("pages", 32'(pages), 32'(want.pages));
      if (entries !== want.entries)
        report_mismatch("entries_used", 32'(entries), 32'(want.entries));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  dkct_in_if  in_if();
  dkct_out_if out_if();

  date_keyed_count_table dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if),
    .out_s (out_if)
  );

  page_tally_scoreboard sb;

  int unsigned burst_left;
  int unsigned stall_pct;
  int unsigned n_record, n_query, n_month, n_other, n_at_full;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stall runs, rate set per stretch by the stimulus
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 12);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_reply(out_if.pages, out_if.entries_used);
  end

  // watchdog: cycles without any transfer on either channel
  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle = 0;
      else
        idle++;
    end
    $display("no transfer for %0d cycles, %0d replies outstanding",
             IDLE_LIMIT, sb.expected_tallies.size());
    $display("TEST FAILED");
    $finish;
  end

  // called and returns at a falling edge
  task automatic send_request(logic [OPCODE_W-1:0] opcode, logic [KEY_W-1:0] day_key,
                              logic [YEAR_W-1:0] year, logic [MONTH_W-1:0] month);
    request_t req;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    req.opcode  = opcode;
    req.day_key = day_key;
    req.year    = year;
    req.month   = month;
    in_if.valid   <= 1'b1;
    in_if.opcode  <= opcode;
    in_if.day_key <= day_key;
    in_if.year    <= year;
    in_if.month   <= month;
    do @(posedge clk); while (!in_if.ready);
    if (sb.fill >= TABLE_DEPTH) n_at_full++;
    sb.accept_request(req);
    case (opcode)
      OP_RECORD: n_record++;
      OP_QUERY:  n_query++;
      OP_MONTH:  n_month++;
      default:   n_other++;
    endcase
    burst_left--;
    @(negedge clk);
  endtask

  function automatic logic [YEAR_W-1:0] pick_year();
    if ($urandom_range(0, 9) == 0) return YEAR_W'($urandom_range(0, 9999));
    return YEAR_W'(2022 + $urandom_range(0, 4));
  endfunction

  function automatic logic [KEY_W-1:0] random_date();
    return KEY_W'(32'(pick_year()) * 10000 + $urandom_range(1, 12) * 100
                  + $urandom_range(1, 31));
  endfunction

  function automatic logic [KEY_W-1:0] fresh_date();
    logic [KEY_W-1:0] k;
    k = random_date();
    for (int i = 0; i < 32 && sb.holds(k); i++) k = random_date();
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] stored_or_random();
    if (sb.fill == 0 || $urandom_range(0, 4) == 0) return random_date();
    return sb.dates[$urandom_range(0, sb.fill - 1)];
  endfunction

  task automatic send_month_query();
    if ($urandom_range(0, 9) == 0)
      send_request(OP_MONTH, KEY_W'($urandom), YEAR_W'($urandom_range(0, 16383)),
                   MONTH_W'($urandom_range(0, 15)));
    else
      send_request(OP_MONTH, KEY_W'($urandom), pick_year(), MONTH_W'($urandom_range(1, 12)));
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: send_request(OP_UNUSED, KEY_W'($urandom_range(0, 99991231)), YEAR_W'($urandom),
                      MONTH_W'($urandom));
      1: send_request(OP_RECORD, '0, YEAR_W'($urandom), MONTH_W'($urandom));
      default: send_request(OP_RECORD, KEY_W'($urandom_range(1, 99991231)), YEAR_W'($urandom),
                            MONTH_W'($urandom));
    endcase
  endtask

  task automatic run_random(int unsigned n_items);
    int unsigned roll;
    logic [KEY_W-1:0] k;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 48 == 0) begin
        case ($urandom_range(0, 3))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 25;
          default: stall_pct = 70;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (sb.fill < TABLE_DEPTH) begin
        // filling: mostly inserts of dates not yet held
        if (roll < 86)      send_request(OP_RECORD, fresh_date(), YEAR_W'($urandom),
                                         MONTH_W'($urandom));
        else if (roll < 90) send_request(OP_RECORD, stored_or_random(), YEAR_W'($urandom),
                                         MONTH_W'($urandom));
        else if (roll < 94) send_request(OP_QUERY, stored_or_random(), YEAR_W'($urandom),
                                         MONTH_W'($urandom));
        else if (roll < 98) send_month_query();
        else                send_noise();
      end else begin
        if (roll < 30) begin
          send_request(OP_RECORD, fresh_date(), YEAR_W'($urandom), MONTH_W'($urandom));
        end else if (roll < 42) begin
          // below every stored date: dropped as soon as it is inserted
          k = (sb.dates[0] > 1) ? KEY_W'($urandom_range(1, sb.dates[0] - 1)) : '0;
          send_request(OP_RECORD, k, YEAR_W'($urandom), MONTH_W'($urandom));
        end else if (roll < 56) begin
          send_request(OP_RECORD, stored_or_random(), YEAR_W'($urandom), MONTH_W'($urandom));
        end else if (roll < 74) begin
          send_request(OP_QUERY, stored_or_random(), YEAR_W'($urandom), MONTH_W'($urandom));
        end else if (roll < 92) begin
          send_month_query();
        end else begin
          send_noise();
        end
      end
    end
  endtask

  initial begin
    sb = new();
    burst_left = 0;
    stall_pct = 0;
    n_record = 0;
    n_query = 0;
    n_month = 0;
    n_other = 0;
    n_at_full = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_RECORD;
    in_if.day_key = '0;
    in_if.year = '0;
    in_if.month = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, ignored records, extremes, month bounds
    send_request(OP_QUERY, '0, '0, '0);
    send_request(OP_MONTH, '0, YEAR_W'(2024), MONTH_W'(3));
    send_request(OP_RECORD, '0, '1, '1);
    send_request(OP_UNUSED, '1, '1, '1);
    send_request(OP_RECORD, KEY_W'(20240315), '0, '0);
    send_request(OP_RECORD, KEY_W'(20240315), '0, '0);
    send_request(OP_RECORD, KEY_W'(20240301), '0, '0);
    send_request(OP_RECORD, KEY_W'(20240331), '0, '0);
    send_request(OP_RECORD, KEY_W'(20240401), '0, '0);
    send_request(OP_RECORD, KEY_W'(20240229), '0, '0);
    send_request(OP_RECORD, KEY_LAST, '0, '0);
    send_request(OP_RECORD, KEY_W'(1), '0, '0);
    send_request(OP_RECORD, KEY_W'(20240331), '0, '0);
    send_request(OP_QUERY, KEY_W'(20240315), '1, '1);
    send_request(OP_QUERY, KEY_W'(20240316), '0, '0);
    send_request(OP_QUERY, '0, '0, '0);
    send_request(OP_QUERY, KEY_LAST, '0, '0);
    send_request(OP_MONTH, '0, YEAR_W'(2024), MONTH_W'(3));
    send_request(OP_MONTH, '0, YEAR_W'(2024), MONTH_W'(4));
    send_request(OP_MONTH, '0, YEAR_W'(9999), MONTH_W'(12));
    // year 0, month 0 spans keys 1..31
    send_request(OP_MONTH, '0, '0, '0);
    send_request(OP_MONTH, '0, '1, '1);
    send_request(OP_MONTH, '0, '0, MONTH_W'(13));
    send_request(OP_UNUSED, '0, '0, '0);

    run_random(RANDOM_ITEMS);

    in_if.valid <= 1'b0;
    stall_pct = 0;
    while (sb.expected_tallies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d records, %0d date queries, %0d month queries, %0d other",
             n_record + n_query + n_month + n_other, n_record, n_query, n_month, n_other);
    $display("Checked %0d replies; table peaked at %0d of %0d entries, %0d requests at full",
             sb.replies_checked, sb.peak_fill, TABLE_DEPTH, n_at_full);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
